// ===== rtl/core/hpmd_pkg.sv =====
package hpmd_pkg;

    localparam int CoefW   = 32;
    localparam int PtW     = 16;
    localparam int OutW    = 24;
    localparam int RowW    = 49;
    localparam int DivW    = 76;
    localparam int QuoW    = 24;
    localparam int SqW     = 52;
    localparam int SqSteps = 26;

    localparam logic [2:0] REG_H00_H01 = 3'd0;
    localparam logic [2:0] REG_H02_H10 = 3'd1;
    localparam logic [2:0] REG_H11_H12 = 3'd2;
    localparam logic [2:0] REG_H20_H21 = 3'd3;
    localparam logic [2:0] REG_H22     = 3'd4;

    typedef struct packed {
        logic signed [PtW-1:0] src_x;
        logic signed [PtW-1:0] src_y;
        logic signed [PtW-1:0] ref_x;
        logic signed [PtW-1:0] ref_y;
    } pt_in_t;

    typedef struct packed {
        logic signed [OutW-1:0] mapped_x;
        logic signed [OutW-1:0] mapped_y;
        logic [OutW-1:0]        dist_res;
        logic                   denom_zero;
    } pt_out_t;

    typedef struct packed {
        logic [DivW-1:0] rem;
        logic            neg;
        logic            ovf;
        logic [QuoW-1:0] quo;
    } div_lane_t;

    typedef struct packed {
        logic                  valid;
        logic                  dz;
        logic [DivW-1:0]       dsh;
        div_lane_t             lx;
        div_lane_t             ly;
        logic signed [PtW-1:0] ref_x;
        logic signed [PtW-1:0] ref_y;
    } div_stage_t;

    typedef struct packed {
        logic                   valid;
        logic                   dz;
        logic signed [OutW-1:0] mx;
        logic signed [OutW-1:0] my;
        logic [SqW-1:0]         rem;
        logic [SqW-1:0]         root;
        logic [SqW-1:0]         bitv;
    } sq_stage_t;

endpackage

// ===== rtl/core/homography_point_map_distance.sv =====
// Channel   | Ports                              | Handshake
// ----------+------------------------------------+-----------------------------------
// point in  | start, busy, pt_in                 | transaction when start && !busy
// result    | done, res                          | one cycle, strobed by done
// config    | cfg_we, cfg_idx, cfg_data          | write when cfg_we is high
//
// One point enters every clock; busy is always low. The pipeline holds
// three front stages (products, row sums, operand prep), 24 divider cells, two
// stages (saturate/diff, squares), one sum stage, 26 square-root cells and the
// output register. Reset clears the pipeline valid bits and loads the identity
// matrix. The receiver cannot stall: take each result in the cycle done
// is high.
module homography_point_map_distance (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  hpmd_pkg::pt_in_t          pt_in,
    output logic                      done,
    output hpmd_pkg::pt_out_t         res,
    input  logic                      cfg_we,
    input  logic [2:0]                cfg_idx,
    input  logic [63:0]               cfg_data
);

    localparam int RW = hpmd_pkg::RowW;
    localparam int DW = hpmd_pkg::DivW;
    localparam int QW = hpmd_pkg::QuoW;
    localparam int SW = hpmd_pkg::SqW;
    localparam int NS = hpmd_pkg::SqSteps;
    localparam int OutW_c = hpmd_pkg::OutW;

    // Coefficient registers
    logic [63:0] c0_reg, c1_reg, c2_reg, c3_reg;
    logic [31:0] c4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c0_reg <= 64'h0010_0000_0000_0000;
            c1_reg <= '0;
            c2_reg <= 64'h0010_0000_0000_0000;
            c3_reg <= '0;
            c4_reg <= 32'h0010_0000;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                hpmd_pkg::REG_H00_H01: c0_reg <= cfg_data;
                hpmd_pkg::REG_H02_H10: c1_reg <= cfg_data;
                hpmd_pkg::REG_H11_H12: c2_reg <= cfg_data;
                hpmd_pkg::REG_H20_H21: c3_reg <= cfg_data;
                hpmd_pkg::REG_H22:     c4_reg <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    logic signed [31:0] h00, h01, h02, h10, h11, h12, h20, h21, h22;
    assign h00 = c0_reg[63:32];
    assign h01 = c0_reg[31:0];
    assign h02 = c1_reg[63:32];
    assign h10 = c1_reg[31:0];
    assign h11 = c2_reg[63:32];
    assign h12 = c2_reg[31:0];
    assign h20 = c3_reg[63:32];
    assign h21 = c3_reg[31:0];
    assign h22 = c4_reg;

    assign busy = 1'b0;

    // Stage 1: six products, constant column scaled by 16
    logic                v1_reg;
    logic signed [47:0]  p00_reg, p01_reg, p10_reg, p11_reg, p20_reg, p21_reg;
    logic signed [35:0]  k0_reg, k1_reg, k2_reg;
    logic signed [15:0]  rx1_reg, ry1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v1_reg <= 1'b0;
        else        v1_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        p00_reg <= h00 * pt_in.src_x;
        p01_reg <= h01 * pt_in.src_y;
        p10_reg <= h10 * pt_in.src_x;
        p11_reg <= h11 * pt_in.src_y;
        p20_reg <= h20 * pt_in.src_x;
        p21_reg <= h21 * pt_in.src_y;
        k0_reg  <= {h02, 4'b0};
        k1_reg  <= {h12, 4'b0};
        k2_reg  <= {h22, 4'b0};
        rx1_reg <= pt_in.ref_x;
        ry1_reg <= pt_in.ref_y;
    end

    // Stage 2: row sums
    logic                v2_reg;
    logic signed [RW-1:0] r0_reg, r1_reg, r2_reg;
    logic signed [15:0]  rx2_reg, ry2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v2_reg <= 1'b0;
        else        v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        r0_reg  <= RW'(p00_reg) + RW'(p01_reg) + RW'(k0_reg);
        r1_reg  <= RW'(p10_reg) + RW'(p11_reg) + RW'(k1_reg);
        r2_reg  <= RW'(p20_reg) + RW'(p21_reg) + RW'(k2_reg);
        rx2_reg <= rx1_reg;
        ry2_reg <= ry1_reg;
    end

    // Stage 3: magnitudes, rounding numerators, overflow check.
    // Quotient is (512*|num| + |den|) / (2*|den|): halves round away from zero.
    logic [RW-1:0] a0, a1, a2;
    logic [DW-1:0] den2, num0, num1, dtop;
    hpmd_pkg::div_stage_t prep_next, prep_reg;

    assign a0   = r0_reg[RW-1] ? RW'(-r0_reg) : RW'(r0_reg);
    assign a1   = r1_reg[RW-1] ? RW'(-r1_reg) : RW'(r1_reg);
    assign a2   = r2_reg[RW-1] ? RW'(-r2_reg) : RW'(r2_reg);
    assign den2 = DW'(a2) << 1;
    assign num0 = (DW'(a0) << 9) + DW'(a2);
    assign num1 = (DW'(a1) << 9) + DW'(a2);
    assign dtop = den2 << QW;

    always_comb
    begin
        prep_next.valid  = v2_reg;
        prep_next.dz     = (r2_reg == '0);
        prep_next.dsh    = den2 << (QW - 1);
        prep_next.lx.rem = num0;
        prep_next.lx.neg = r0_reg[RW-1] ^ r2_reg[RW-1];
        prep_next.lx.ovf = (num0 >= dtop);
        prep_next.lx.quo = '0;
        prep_next.ly.rem = num1;
        prep_next.ly.neg = r1_reg[RW-1] ^ r2_reg[RW-1];
        prep_next.ly.ovf = (num1 >= dtop);
        prep_next.ly.quo = '0;
        prep_next.ref_x  = rx2_reg;
        prep_next.ref_y  = ry2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) prep_reg <= '0;
        else        prep_reg <= prep_next;
    end

    // Divider chain: one quotient bit per cell, both lanes side by side
    hpmd_pkg::div_stage_t dchain [QW+1];
    assign dchain[0] = prep_reg;

    for (genvar i = 0; i < QW; i++)
    begin : g_div
        hpmd_div_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .d     (dchain[i]),
            .q     (dchain[i+1])
        );
    end

    hpmd_pkg::div_stage_t dq;
    assign dq = dchain[QW];

    // Stage 4: saturate quotients, take differences to the reference
    logic signed [OutW_c-1:0] mx_s, my_s;
    localparam logic signed [OutW_c-1:0] SatMax = {1'b0, {(OutW_c-1){1'b1}}};
    localparam logic signed [OutW_c-1:0] SatMin = {1'b1, {(OutW_c-1){1'b0}}};
    localparam logic [QW:0] NegLim = {2'b01, {(QW-1){1'b0}}};

    always_comb
    begin
        if (dq.lx.neg)
            mx_s = (dq.lx.ovf || ({1'b0, dq.lx.quo} > NegLim)) ? SatMin
                 : OutW_c'(-$signed({1'b0, dq.lx.quo}));
        else
            mx_s = (dq.lx.ovf || dq.lx.quo[QW-1]) ? SatMax : OutW_c'(dq.lx.quo);
        if (dq.ly.neg)
            my_s = (dq.ly.ovf || ({1'b0, dq.ly.quo} > NegLim)) ? SatMin
                 : OutW_c'(-$signed({1'b0, dq.ly.quo}));
        else
            my_s = (dq.ly.ovf || dq.ly.quo[QW-1]) ? SatMax : OutW_c'(dq.ly.quo);
    end

    logic                v4_reg, dz4_reg;
    logic signed [OutW_c-1:0] mx4_reg, my4_reg;
    logic signed [25:0]  dx4_reg, dy4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v4_reg <= 1'b0;
        else        v4_reg <= dq.valid;
    end

    always_ff @(posedge clk)
    begin
        dz4_reg <= dq.dz;
        mx4_reg <= mx_s;
        my4_reg <= my_s;
        dx4_reg <= 26'(mx_s) - 26'($signed({dq.ref_x, 4'b0}));
        dy4_reg <= 26'(my_s) - 26'($signed({dq.ref_y, 4'b0}));
    end

    // Stage 5: squares
    logic [24:0] adx, ady;
    assign adx = dx4_reg[25] ? 25'(-dx4_reg) : 25'(dx4_reg);
    assign ady = dy4_reg[25] ? 25'(-dy4_reg) : 25'(dy4_reg);

    logic                v5_reg, dz5_reg;
    logic signed [OutW_c-1:0] mx5_reg, my5_reg;
    logic [49:0]         sx5_reg, sy5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v5_reg <= 1'b0;
        else        v5_reg <= v4_reg;
    end

    always_ff @(posedge clk)
    begin
        dz5_reg <= dz4_reg;
        mx5_reg <= mx4_reg;
        my5_reg <= my4_reg;
        sx5_reg <= adx * adx;
        sy5_reg <= ady * ady;
    end

    // Stage 6: sum of squares, seed the root chain
    hpmd_pkg::sq_stage_t sq0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq0_reg <= '0;
        end
        else
        begin
            sq0_reg.valid <= v5_reg;
            sq0_reg.dz    <= dz5_reg;
            sq0_reg.mx    <= mx5_reg;
            sq0_reg.my    <= my5_reg;
            sq0_reg.rem   <= SW'(sx5_reg) + SW'(sy5_reg);
            sq0_reg.root  <= '0;
            sq0_reg.bitv  <= SW'(1) << (2 * NS - 2);
        end
    end

    // Square-root chain: one root bit per cell
    hpmd_pkg::sq_stage_t schain [NS+1];
    assign schain[0] = sq0_reg;

    for (genvar j = 0; j < NS; j++)
    begin : g_sqrt
        hpmd_sqrt_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .d     (schain[j]),
            .q     (schain[j+1])
        );
    end

    hpmd_pkg::sq_stage_t sq;
    assign sq = schain[NS];

    // Output: round the root half up, saturate, zero on a zero denominator
    logic [SW-1:0] root_rnd;
    assign root_rnd = sq.root + SW'(sq.rem > sq.root);

    logic              done_reg;
    hpmd_pkg::pt_out_t res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) done_reg <= 1'b0;
        else        done_reg <= sq.valid;
    end

    always_ff @(posedge clk)
    begin
        res_reg.denom_zero <= sq.dz;
        if (sq.dz)
        begin
            res_reg.mapped_x <= '0;
            res_reg.mapped_y <= '0;
            res_reg.dist_res <= '0;
        end
        else
        begin
            res_reg.mapped_x <= sq.mx;
            res_reg.mapped_y <= sq.my;
            res_reg.dist_res <= (root_rnd[SW-1:OutW_c] != '0) ? {OutW_c{1'b1}}
                              : root_rnd[OutW_c-1:0];
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

// ===== rtl/core/hpmd_div_cell.sv =====
module hpmd_div_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  hpmd_pkg::div_stage_t d,
    output hpmd_pkg::div_stage_t q
);

    hpmd_pkg::div_stage_t q_reg;
    hpmd_pkg::div_stage_t q_next;

    // One restoring quotient bit per lane; divisor shifts down one place.
    always_comb
    begin
        q_next = d;
        q_next.dsh = d.dsh >> 1;
        if (d.lx.rem >= d.dsh)
        begin
            q_next.lx.rem = d.lx.rem - d.dsh;
            q_next.lx.quo = {d.lx.quo[hpmd_pkg::QuoW-2:0], 1'b1};
        end
        else
        begin
            q_next.lx.quo = {d.lx.quo[hpmd_pkg::QuoW-2:0], 1'b0};
        end
        if (d.ly.rem >= d.dsh)
        begin
            q_next.ly.rem = d.ly.rem - d.dsh;
            q_next.ly.quo = {d.ly.quo[hpmd_pkg::QuoW-2:0], 1'b1};
        end
        else
        begin
            q_next.ly.quo = {d.ly.quo[hpmd_pkg::QuoW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= '0;
        end
        else
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

// ===== rtl/core/hpmd_sqrt_cell.sv =====
module hpmd_sqrt_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  hpmd_pkg::sq_stage_t d,
    output hpmd_pkg::sq_stage_t q
);

    hpmd_pkg::sq_stage_t q_reg;
    hpmd_pkg::sq_stage_t q_next;
    logic [hpmd_pkg::SqW-1:0] trial;

    // One root bit per cell: try root+bit against the remainder.
    always_comb
    begin
        trial  = d.root + d.bitv;
        q_next = d;
        q_next.bitv = d.bitv >> 2;
        if (d.rem >= trial)
        begin
            q_next.rem  = d.rem - trial;
            q_next.root = (d.root >> 1) + d.bitv;
        end
        else
        begin
            q_next.root = d.root >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= '0;
        end
        else
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

// ===== sim/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Any index above the last coefficient register is dropped by the block.
    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam int         IDLE_LIMIT = 4000;
    localparam int         FLUSH_CYCLES = 80;

    // Coefficient generation styles for the random phases.
    typedef enum int {
        COEF_NEAR_IDENTITY,
        COEF_RANDOM,
        COEF_EXTREME,
        COEF_ZERO_DENOM
    } coef_style_e;

    typedef struct {
        hpmd_pkg::pt_in_t  pt;
        bit                typed;
        hpmd_pkg::pt_out_t want;
    } stim_row_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    hpmd_pkg::pt_in_t  pt_in;
    logic              done;
    hpmd_pkg::pt_out_t res;
    logic              cfg_we;
    logic [2:0]        cfg_idx;
    logic [63:0]       cfg_data;

    // Row-level expectation that travels with the point being driven.
    logic              row_typed;
    hpmd_pkg::pt_out_t row_want;

    logic [63:0]       coef_mirror [5];
    hpmd_pkg::pt_out_t expected_results[$];
    int          mismatch_count;
    int          idle_cycles;
    int          points_sent;
    int          results_seen;
    int          denom_zero_seen;
    int          saturated_seen;
    int          phases_run;
    bit          no_gap_window;

    homography_point_map_distance u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .pt_in    (pt_in),
        .done     (done),
        .res      (res),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor: projective map, rounded divide, rounded square root.
    // ------------------------------------------------------------------
    function automatic longint coef_hi(logic [63:0] w);
        return longint'(signed'(w[63:32]));
    endfunction

    function automatic longint coef_lo(logic [63:0] w);
        return longint'(signed'(w[31:0]));
    endfunction

    // Quotient scaled by 256, halves away from zero, clamped to 24 bits signed.
    function automatic longint divide_q16_8(longint num, longint den);
        bit          neg;
        bit [63:0]   n;
        bit [63:0]   d;
        bit [63:0]   q;
        neg = (num < 0) != (den < 0);
        n = (num < 0 ? -num : num) * 256;
        d = den < 0 ? -den : den;
        q = (2 * n + d) / (2 * d);
        if (neg)
            return (q > 64'd8388608) ? -longint'(8388608) : -longint'(q);
        return (q > 64'd8388607) ? longint'(8388607) : longint'(q);
    endfunction

    // Bitwise root, rounded to nearest with halves going up.
    function automatic bit [63:0] root_rounded(bit [63:0] v);
        bit [63:0] r;
        bit [63:0] b;
        bit [63:0] x;
        r = 0;
        b = 64'd1 << 62;
        x = v;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        if (x > r)
            r += 1;
        return r;
    endfunction

    function automatic hpmd_pkg::pt_out_t map_point(hpmd_pkg::pt_in_t p);
        hpmd_pkg::pt_out_t o;
        longint    x, y, r0, r1, r2, mx, my, dx, dy;
        bit [63:0] span;
        x  = longint'(p.src_x);
        y  = longint'(p.src_y);
        r0 = coef_hi(coef_mirror[0]) * x + coef_lo(coef_mirror[0]) * y
           + coef_hi(coef_mirror[1]) * 16;
        r1 = coef_lo(coef_mirror[1]) * x + coef_hi(coef_mirror[2]) * y
           + coef_lo(coef_mirror[2]) * 16;
        r2 = coef_hi(coef_mirror[3]) * x + coef_lo(coef_mirror[3]) * y
           + coef_lo(coef_mirror[4]) * 16;
        o = '0;
        if (r2 == 0)
        begin
            o.denom_zero = 1'b1;
            return o;
        end
        mx = divide_q16_8(r0, r2);
        my = divide_q16_8(r1, r2);
        dx = mx - longint'(p.ref_x) * 16;
        dy = my - longint'(p.ref_y) * 16;
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        span = root_rounded(dx * dx + dy * dy);
        if (span > 64'hFFFFFF)
            span = 64'hFFFFFF;
        o.mapped_x = mx[23:0];
        o.mapped_y = my[23:0];
        o.dist_res = span[23:0];
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Scoreboard
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, longint got, longint want);
        $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Append one expectation at the tail of the queue.
    function automatic void queue_expected(hpmd_pkg::pt_out_t w);
        expected_results = {expected_results, w};
    endfunction

    // Record each accepted point; expectation is the typed row or the predictor.
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            queue_expected(row_typed ? row_want : map_point(pt_in));
            points_sent++;
        end
    end

    // Compare each strobed result against the oldest expectation.
    always @(posedge clk)
    begin
        hpmd_pkg::pt_out_t want;
        if (rst_n && done)
        begin
            results_seen++;
            if (res.denom_zero)
                denom_zero_seen++;
            if (res.mapped_x == 24'h7FFFFF || res.mapped_x == 24'h800000)
                saturated_seen++;
            if (expected_results.size() == 0)
                report_mismatch("unexpected result", 1, 0);
            else
            begin
                want = expected_results.pop_front();
                if (res.mapped_x !== want.mapped_x)
                    report_mismatch("mapped_x", res.mapped_x, want.mapped_x);
                if (res.mapped_y !== want.mapped_y)
                    report_mismatch("mapped_y", res.mapped_y, want.mapped_y);
                if (res.dist_res !== want.dist_res)
                    report_mismatch("dist_res", res.dist_res, want.dist_res);
                if (res.denom_zero !== want.denom_zero)
                    report_mismatch("denom_zero", res.denom_zero, want.denom_zero);
            end
        end
    end

    // Watchdog: end the run if no transaction moves for too long.
    always @(posedge clk)
    begin
        if ((start && !busy) || done || cfg_we || !rst_n)
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog expired with %0d results pending",
                         expected_results.size());
                $display("FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [15:0] pick_coord();
        case ($urandom_range(0, 7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'($signed($urandom_range(0, 64)) - 32);
            4:       return 16'($signed($urandom_range(0, 4096)) - 2048);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_coef(coef_style_e style, int slot);
        logic [31:0] one;
        one = 32'h0010_0000;
        case (style)
            COEF_NEAR_IDENTITY:
                case (slot)
                    0, 4, 8: return one + 32'($signed($urandom_range(0, 131072)) - 65536);
                    2, 5:    return 32'($signed($urandom_range(0, 134217728)) - 67108864);
                    6, 7:    return 32'($signed($urandom_range(0, 512)) - 256);
                    default: return 32'($signed($urandom_range(0, 32768)) - 16384);
                endcase
            COEF_EXTREME:
                case ($urandom_range(0, 5))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7FFF_FFFF;
                    2:       return 32'h0000_0000;
                    3:       return 32'h0000_0001;
                    4:       return 32'hFFFF_FFFF;
                    default: return one;
                endcase
            COEF_ZERO_DENOM:
                // Bottom row collapses so the denominator vanishes on a line or everywhere.
                case (slot)
                    6:       return $urandom_range(0, 1) ? one : 32'h0;
                    7:       return $urandom_range(0, 1) ? 32'hFFF0_0000 : 32'h0;
                    8:       return 32'h0;
                    default: return $urandom;
                endcase
            default:
                return $urandom;
        endcase
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [63:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we   <= 1'b0;
        if (idx <= hpmd_pkg::REG_H22)
            coef_mirror[idx] = (idx == hpmd_pkg::REG_H22) ? {32'h0, data[31:0]} : data;
    endtask

    // Load a full 3x3 matrix, coefficients listed row-major h00..h22.
    task automatic load_matrix(logic [31:0] h [9]);
        write_reg(hpmd_pkg::REG_H00_H01, {h[0], h[1]});
        write_reg(hpmd_pkg::REG_H02_H10, {h[2], h[3]});
        write_reg(hpmd_pkg::REG_H11_H12, {h[4], h[5]});
        write_reg(hpmd_pkg::REG_H20_H21, {h[6], h[7]});
        // Upper half of the h22 write carries junk; the block must drop it.
        write_reg(hpmd_pkg::REG_H22, {$urandom, h[8]});
        write_reg(REG_UNUSED - 3'($urandom_range(0, 2)), {$urandom, $urandom});
        @(posedge clk);
    endtask

    // Hold until every expected result has come back.
    task automatic drain();
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Drive one point; idle at random outside the no-gap window.
    task automatic drive_point(hpmd_pkg::pt_in_t p, bit typed, hpmd_pkg::pt_out_t want);
        if (!no_gap_window)
        begin
            while ($urandom_range(0, 99) < 6)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
        end
        start     <= 1'b1;
        pt_in     <= p;
        row_typed <= typed;
        row_want  <= want;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic run_phase(coef_style_e style, int count);
        logic [31:0]      h [9];
        hpmd_pkg::pt_in_t p;
        for (int i = 0; i < 9; i++)
            h[i] = pick_coef(style, i);
        load_matrix(h);
        phases_run++;
        for (int n = 0; n < count; n++)
        begin
            p.src_x = pick_coord();
            p.src_y = pick_coord();
            // Take each reference from the source point half the time so distances stay meaningful.
            p.ref_x = $urandom_range(0, 1) ? pick_coord() : p.src_x;
            p.ref_y = $urandom_range(0, 1) ? pick_coord() : p.src_y;
            drive_point(p, 1'b0, '0);
        end
        start <= 1'b0;
        @(posedge clk);
        drain();
    endtask

    // ------------------------------------------------------------------
    // Directed rows, run under the reset (identity) matrix. Under identity
    // a Q12.4 coordinate maps exactly to itself scaled by 16 in Q16.8.
    // ------------------------------------------------------------------
    stim_row_t directed_rows [] = '{
        '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, '{24'sd0, 24'sd0, 24'd0, 1'b0}},
        '{'{16'sd1, 16'sd0, 16'sd0, 16'sd0}, 1'b1, '{24'sd16, 24'sd0, 24'd16, 1'b0}},
        '{'{16'sd0, -16'sd1, 16'sd0, 16'sd0}, 1'b1, '{24'sd0, -24'sd16, 24'd16, 1'b0}},
        '{'{16'sd3, 16'sd4, 16'sd0, 16'sd0}, 1'b1, '{24'sd48, 24'sd64, 24'd80, 1'b0}},
        '{'{16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768}, 1'b1,
          '{24'sd524272, -24'sd524288, 24'd0, 1'b0}},
        '{'{16'sd32767, 16'sd0, -16'sd32768, 16'sd0}, 1'b1,
          '{24'sd524272, 24'sd0, 24'd1048560, 1'b0}},
        '{'{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768}, 1'b1,
          '{-24'sd524288, -24'sd524288, 24'd0, 1'b0}},
        '{'{16'sh5555, 16'shAAAA, 16'sh2AAA, -16'sh2AAA}, 1'b0, '0},
        '{'{16'sh7F00, 16'sh00FF, 16'sh8001, 16'sh7FFE}, 1'b0, '0},
        '{'{-16'sd1, -16'sd1, -16'sd1, -16'sd1}, 1'b1, '{-24'sd16, -24'sd16, 24'd0, 1'b0}}
    };

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [31:0] h [9];
        start     = 1'b0;
        pt_in     = '0;
        cfg_we    = 1'b0;
        cfg_idx   = hpmd_pkg::REG_H00_H01;
        cfg_data  = '0;
        row_typed = 1'b0;
        row_want  = '0;
        rst_n     = 1'b0;
        mismatch_count = 0;
        idle_cycles    = 0;
        points_sent    = 0;
        results_seen   = 0;
        denom_zero_seen = 0;
        saturated_seen  = 0;
        phases_run      = 0;
        no_gap_window   = 1'b0;
        coef_mirror[0] = 64'h0010_0000_0000_0000;
        coef_mirror[1] = 64'h0;
        coef_mirror[2] = 64'h0010_0000_0000_0000;
        coef_mirror[3] = 64'h0;
        coef_mirror[4] = 64'h0010_0000;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            drive_point(directed_rows[i].pt, directed_rows[i].typed, directed_rows[i].want);
        start <= 1'b0;
        @(posedge clk);
        drain();

        // Denominator of 256.0 shrinks the map by 256: odd multiples of 8 land on exact halves.
        h = '{32'h0010_0000, 32'h0, 32'h0, 32'h0, 32'h0010_0000, 32'h0, 32'h0, 32'h0,
              32'h1000_0000};
        load_matrix(h);
        for (int v = -24; v <= 24; v += 8)
            drive_point('{16'(v), 16'(-v), 16'sd0, 16'sd0}, 1'b0, '0);
        start <= 1'b0;
        @(posedge clk);
        drain();

        // Huge gain over a tiny denominator: both coordinates pin to the rails.
        h = '{32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h8000_0000, 32'h0, 32'h0, 32'h0,
              32'h0000_0001};
        load_matrix(h);
        drive_point('{16'sd32767, 16'sd32767, -16'sd32768, 16'sd32767}, 1'b0, '0);
        drive_point('{-16'sd32768, -16'sd32768, 16'sd32767, -16'sd32768}, 1'b0, '0);
        start <= 1'b0;
        @(posedge clk);
        drain();

        // Whole bottom row zero: every point reports a zero denominator.
        h = '{32'h0010_0000, 32'h0, 32'h0, 32'h0, 32'h0010_0000, 32'h0, 32'h0, 32'h0,
              32'h0};
        load_matrix(h);
        drive_point('{16'sd100, -16'sd100, 16'sd5, 16'sd5}, 1'b1, '{24'sd0, 24'sd0, 24'd0, 1'b1});
        drive_point('{16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF}, 1'b1,
                    '{24'sd0, 24'sd0, 24'd0, 1'b1});
        start <= 1'b0;
        @(posedge clk);
        drain();

        // Random phases; one of them runs without gaps end to end.
        for (int ph = 0; ph < 10; ph++)
        begin
            no_gap_window = (ph == 4);
            case (ph % 4)
                0:       run_phase(COEF_NEAR_IDENTITY, 60);
                1:       run_phase(COEF_RANDOM, 45);
                2:       run_phase(COEF_EXTREME, 45);
                default: run_phase(COEF_ZERO_DENOM, 35);
            endcase
        end
        no_gap_window = 1'b0;

        // Back to identity so the reset values are rewritten too.
        h = '{32'h0010_0000, 32'h0, 32'h0, 32'h0, 32'h0010_0000, 32'h0, 32'h0, 32'h0,
              32'h0010_0000};
        load_matrix(h);
        run_phase(COEF_NEAR_IDENTITY, 30);

        drain();
        repeat (FLUSH_CYCLES) @(posedge clk);

        $display("covered %0d points over %0d coefficient phases plus directed rows",
                 points_sent, phases_run);
        $display("results %0d, zero denominators %0d, saturated x %0d, mismatches %0d",
                 results_seen, denom_zero_seen, saturated_seen, mismatch_count);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/hpmd_pkg.sv
rtl/core/hpmd_div_cell.sv
rtl/core/hpmd_sqrt_cell.sv
rtl/core/homography_point_map_distance.sv
sim/testbench.sv
